/* rtl/mpvl_pkg.sv */
package mpvl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16384;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int PREFIX_W    = 24;
    localparam int OFFSET_W    = 16;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 15;
    localparam int DIGIT_W     = 3;
    localparam int STATUS_W    = 2;

    localparam logic [DIGIT_W-1:0] PREFIX_DIGITS = 3'd6;
    // Locally administered flag: bit 0x02 of the first octet
    localparam int LOCAL_BIT   = 17;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CHAR = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        RES_FOUND   = 2'd0,
        RES_TOO_FEW = 2'd1,
        RES_LOCAL   = 2'd2,
        RES_ABSENT  = 2'd3
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_PROBE,
        S_COMPARE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    accept;
        logic    init_search;
        logic    issue_read;
        logic    step_lo;
        logic    step_hi;
        logic    finish;
        t_result result;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic digits_ok;
        logic local_adm;
        logic range_open;
        logic equal;
        logic less;
    } t_stat;

endpackage

/* rtl/mpvl_ctrl.sv */
module mpvl_ctrl
    import mpvl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_op,
    input  logic  i_last,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_CHAR) && i_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.digits_ok && !i_stat.local_adm) begin
                    n_state = S_PROBE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PROBE: begin
                if (i_stat.range_open) begin
                    n_state = S_COMPARE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_COMPARE: begin
                if (i_stat.equal) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PROBE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.result      = RES_FOUND;
        o_cmd.accept      = accept;
        unique case (r_state)
            S_IDLE: begin
            end
            S_CHECK: begin
                if (!i_stat.digits_ok) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.result = RES_TOO_FEW;
                end else if (i_stat.local_adm) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.result = RES_LOCAL;
                end else begin
                    o_cmd.init_search = 1'b1;
                end
            end
            S_PROBE: begin
                if (i_stat.range_open) begin
                    o_cmd.issue_read = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    o_cmd.result = RES_ABSENT;
                end
            end
            S_COMPARE: begin
                if (i_stat.equal) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.result = RES_FOUND;
                end else if (i_stat.less) begin
                    o_cmd.step_lo = 1'b1;
                end else begin
                    o_cmd.step_hi = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/mpvl_dpath.sv */
module mpvl_dpath
    import mpvl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_op,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [PREFIX_W-1:0] i_entry_prefix,
    input  logic [OFFSET_W-1:0] i_entry_string_offset,
    input  logic [CHAR_W-1:0]   i_mac_char,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    output t_stat               o_stat,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [OFFSET_W-1:0] o_vendor_string_offset,
    output logic [IDX_W-1:0]    o_matched_index
);

    localparam int ENTRY_W = PREFIX_W + OFFSET_W;

    logic [ENTRY_W-1:0]  r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]  r_rd_data;
    logic [COUNT_W-1:0]  r_entry_count;
    logic [PREFIX_W-1:0] r_acc;
    logic [DIGIT_W-1:0]  r_digits;
    logic                r_ended;
    logic [PTR_W-1:0]    r_lo;
    logic [PTR_W-1:0]    r_hi;
    logic [IDX_W-1:0]    r_mid;
    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    logic [OFFSET_W-1:0] r_voff;
    logic [IDX_W-1:0]    r_midx;

    logic [PTR_W-1:0]    n_mid;
    logic [PTR_W-1:0]    n_hi;
    logic                hex_ok;
    logic [3:0]          hex_val;
    logic                char_item;
    logic                load_item;
    logic [PREFIX_W-1:0] rd_prefix;

    assign char_item = i_cmd.accept && (i_op == OP_CHAR);
    assign load_item = i_cmd.accept && (i_op == OP_LOAD);
    assign rd_prefix = r_rd_data[ENTRY_W-1:OFFSET_W];

    // Decode one hex digit in either letter case
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_mac_char >= "0" && i_mac_char <= "9") begin
            hex_val = 4'(i_mac_char - "0");
        end else if (i_mac_char >= "A" && i_mac_char <= "F") begin
            hex_val = 4'(i_mac_char - "A" + 8'd10);
        end else if (i_mac_char >= "a" && i_mac_char <= "f") begin
            hex_val = 4'(i_mac_char - "a" + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // Search bounds: midpoint and clamped upper limit
    assign n_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign n_hi  = ({1'b0, r_entry_count} > (COUNT_W + 1)'(TABLE_DEPTH))
                 ? PTR_W'(TABLE_DEPTH) : PTR_W'(r_entry_count);

    // Status towards the controller
    assign o_stat.digits_ok  = (r_digits == PREFIX_DIGITS);
    assign o_stat.local_adm  = r_acc[LOCAL_BIT];
    assign o_stat.range_open = (r_lo < r_hi);
    assign o_stat.equal      = (rd_prefix == r_acc);
    assign o_stat.less       = (rd_prefix < r_acc);

    // Table memory: write on load, registered read on probe
    always_ff @(posedge i_clk) begin
        if (load_item && ({1'b0, i_entry_index} < (IDX_W + 1)'(TABLE_DEPTH))) begin
            r_mem[i_entry_index] <= {i_entry_prefix, i_entry_string_offset};
        end
        if (i_cmd.issue_read) begin
            r_rd_data <= r_mem[n_mid[IDX_W-1:0]];
        end
    end

    // Entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // Parse address text; clear once the result is out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_digits <= '0;
            r_ended  <= 1'b0;
        end else if (i_cmd.finish) begin
            r_acc    <= '0;
            r_digits <= '0;
            r_ended  <= 1'b0;
        end else if (char_item && !r_ended) begin
            if (i_mac_char == '0) begin
                r_ended <= 1'b1;
            end else if (hex_ok && (r_digits < PREFIX_DIGITS)) begin
                r_acc    <= {r_acc[PREFIX_W-5:0], hex_val};
                r_digits <= r_digits + 1'b1;
            end
        end
    end

    // Binary search bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_search) begin
            r_lo <= '0;
            r_hi <= n_hi;
        end else if (i_cmd.step_lo) begin
            r_lo <= PTR_W'(r_mid) + 1'b1;
        end else if (i_cmd.step_hi) begin
            r_hi <= PTR_W'(r_mid);
        end
        if (i_cmd.issue_read) begin
            r_mid <= n_mid[IDX_W-1:0];
        end
    end

    // Result registers and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= i_cmd.result;
            if (i_cmd.result == RES_FOUND) begin
                r_voff <= r_rd_data[OFFSET_W-1:0];
                r_midx <= r_mid;
            end else begin
                r_voff <= '0;
                r_midx <= '0;
            end
        end
    end

    assign o_valid                = r_valid;
    assign o_status               = r_status;
    assign o_vendor_string_offset = r_voff;
    assign o_matched_index        = r_midx;

endmodule

/* rtl/mac_prefix_vendor_lookup_top.sv */
// Load items and non-final characters are taken while idle; busy stays low for them.
// A final character raises busy; a check ends it on too few digits or a local prefix,
// else a binary search runs at most 15 probes for 16384 entries, each one registered
// table read then one compare; a hit ends on its compare, a miss on the probe that
// finds the range empty. The strobe rises next cycle; the receiver cannot stall it.
// Synchronous active-low reset clears control, parse state and entry_count.
module mac_prefix_vendor_lookup_top
    import mpvl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_op,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [PREFIX_W-1:0] i_entry_prefix,
    input  logic [OFFSET_W-1:0] i_entry_string_offset,
    input  logic [CHAR_W-1:0]   i_mac_char,
    input  logic                i_last,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [OFFSET_W-1:0] o_vendor_string_offset,
    output logic [IDX_W-1:0]    o_matched_index
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    mpvl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_op),
        .i_last  (i_last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Parser, table and search datapath
    mpvl_dpath u_dpath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .i_op                   (i_op),
        .i_entry_index          (i_entry_index),
        .i_entry_prefix         (i_entry_prefix),
        .i_entry_string_offset  (i_entry_string_offset),
        .i_mac_char             (i_mac_char),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .o_stat                 (stat),
        .o_valid                (o_valid),
        .o_status               (o_status),
        .o_vendor_string_offset (o_vendor_string_offset),
        .o_matched_index        (o_matched_index)
    );

endmodule

/* rtl/mpvl_checker.sv */
module mpvl_checker
    import mpvl_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                i_op,
    input logic                i_last,
    input logic                o_valid,
    input logic [STATUS_W-1:0] o_status,
    input logic [OFFSET_W-1:0] o_vendor_string_offset,
    input logic [IDX_W-1:0]    o_matched_index
);

    // Final character starts a lookup
    a_last_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == OP_CHAR) && i_last) |=> o_busy)
        else $error("final character did not start a lookup");

    // Load transaction never produces a result nor blocks
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == OP_LOAD)) |=> (!o_busy && !o_valid))
        else $error("load transaction produced a result or raised busy");

    // A result comes with the block idle and stands for one cycle only
    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_busy ##1 !o_valid))
        else $error("result strobe with the block busy or held past one cycle");

    // Offset and index are zero unless found
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != RES_FOUND)) |->
            ((o_vendor_string_offset == '0) && (o_matched_index == '0)))
        else $error("non-zero fields on a miss");

endmodule

bind mac_prefix_vendor_lookup_top mpvl_checker u_mpvl_checker (.*);
